// ----- hw/rtl/hashed_page_table_insert_unit_macros.svh -----
// assertion macros for the hashed page table insert unit
`ifndef HASHED_PAGE_TABLE_INSERT_UNIT_MACROS_SVH
`define HASHED_PAGE_TABLE_INSERT_UNIT_MACROS_SVH

// condition must hold at every edge outside reset
`define HPTI_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("hpti check failed");

// consequent must hold in the cycle after the antecedent
`define HPTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpti check failed");

`endif

// ----- hw/rtl/hpti_pkg.sv -----
// types and constants shared by the page table insert unit
`timescale 1ns / 1ps
`default_nettype none

package hpti_pkg;

  localparam int unsigned VSID_W      = 19;
  localparam int unsigned PAGE_W      = 20;
  localparam int unsigned RPN_W       = 20;
  localparam int unsigned WIMG_W      = 4;
  localparam int unsigned PP_W        = 2;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned SLOTS       = 8;
  localparam int unsigned OUT_GRP_W   = 10;
  localparam int unsigned HASH_W      = 19;
  localparam int unsigned HASH_PAGE_W = 16;
  localparam int unsigned API_W       = 6;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned ENTRY_W     = 64;

  typedef logic [SLOTS-1:0] valid_map_t;

  typedef struct packed {
    logic [VSID_W-1:0] segment_id;
    logic [PAGE_W-1:0] effective_page;
    logic [RPN_W-1:0]  physical_page;
    logic [WIMG_W-1:0] attributes;
    logic [PP_W-1:0]   protection;
  } in_t;

  typedef struct packed {
    logic                 inserted;
    logic                 used_secondary;
    logic [OUT_GRP_W-1:0] group_index;
    logic [SLOT_W-1:0]    slot;
    logic [WORD_W-1:0]    entry_high;
    logic [WORD_W-1:0]    entry_low;
  } out_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } free_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hashed_page_table_insert_unit.sv -----
// flow: an accepted insert reads its primary group's valid map (registered read) and
// searches it in ST_PRIM; a full primary group sends it to the complement group in ST_SEC;
// a result waits while out_stall_i holds the output; a new insert is taken only in ST_IDLE
// reset: the valid map is swept clear, all 2^(TABLE_LOG2-6) groups (1024 by default),
// with in_stall_o high; the entry store is not cleared
`timescale 1ns / 1ps
`default_nettype none

module hashed_page_table_insert_unit
  import hpti_pkg::*;
#(
  parameter int unsigned TABLE_LOG2 = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_o
);

  localparam int unsigned GROUP_W  = TABLE_LOG2 - 6;
  localparam int unsigned ENTRY_AW = GROUP_W + SLOT_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRIM,
    ST_SEC
  } state_e;

  state_e             state_q, state_d;
  logic [GROUP_W-1:0] clr_q, clr_d;
  logic [GROUP_W-1:0] grp_q, grp_d;
  in_t                item_q, item_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic               accept;
  logic               can_finish;
  logic [HASH_W-1:0]  hash_in;
  logic [GROUP_W-1:0] grp_in;

  logic               vm_we;
  logic [GROUP_W-1:0] vm_waddr;
  valid_map_t         vm_wdata;
  logic               vm_re;
  logic [GROUP_W-1:0] vm_raddr;
  valid_map_t         vm_rdata;

  logic                es_we;
  logic [ENTRY_AW-1:0] es_waddr;
  logic [ENTRY_W-1:0]  es_wdata;

  free_t       free;
  logic [WORD_W-1:0] word_high;
  logic [WORD_W-1:0] word_low;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign can_finish  = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign hash_in = in_i.segment_id ^ HASH_W'(in_i.effective_page[HASH_PAGE_W-1:0]);
  assign grp_in  = hash_in[GROUP_W-1:0];

  hpti_slot_finder u_finder (
    .valid_map_i (vm_rdata),
    .free_o      (free)
  );

  assign word_high = {1'b1, 5'b0, item_q.segment_id, (state_q == ST_SEC),
                      item_q.effective_page[HASH_PAGE_W-1 -: API_W]};
  assign word_low  = {item_q.physical_page, 3'b0, 1'b0, 1'b0, item_q.attributes,
                      1'b0, item_q.protection};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    grp_d       = grp_q;
    item_d      = item_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    vm_we       = 1'b0;
    vm_waddr    = grp_q;
    vm_wdata    = vm_rdata | (valid_map_t'(1) << free.slot);
    vm_re       = 1'b0;
    vm_raddr    = grp_in;
    es_we       = 1'b0;
    es_waddr    = {grp_q, free.slot};
    es_wdata    = {word_high, word_low};

    unique case (state_q)
      ST_CLEAR: begin
        vm_we    = 1'b1;
        vm_waddr = clr_q;
        vm_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          vm_re   = 1'b1;
          item_d  = in_i;
          grp_d   = grp_in;
          state_d = ST_PRIM;
        end
      end
      ST_PRIM, ST_SEC: begin
        if (free.found) begin
          if (can_finish) begin
            vm_we                = 1'b1;
            es_we                = 1'b1;
            out_valid_d          = 1'b1;
            out_d.inserted       = 1'b1;
            out_d.used_secondary = (state_q == ST_SEC);
            out_d.group_index    = grp_q[OUT_GRP_W-1:0];
            out_d.slot           = free.slot;
            out_d.entry_high     = word_high;
            out_d.entry_low      = word_low;
            state_d              = ST_IDLE;
          end
        end else if (state_q == ST_PRIM) begin
          // primary group full, fetch the complement group
          vm_re    = 1'b1;
          vm_raddr = ~grp_q;
          grp_d    = ~grp_q;
          state_d  = ST_SEC;
        end else if (can_finish) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      grp_q       <= '0;
      item_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      grp_q       <= grp_d;
      item_q      <= item_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  hpti_valid_ram #(
    .ADDR_W (GROUP_W)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (vm_we),
    .waddr_i (vm_waddr),
    .wdata_i (vm_wdata),
    .re_i    (vm_re),
    .raddr_i (vm_raddr),
    .rdata_o (vm_rdata)
  );

  hpti_entry_store #(
    .ADDR_W (ENTRY_AW)
  ) u_entry_store (
    .clk_i   (clk_i),
    .we_i    (es_we),
    .waddr_i (es_waddr),
    .wdata_i (es_wdata)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/hpti_valid_ram.sv -----
// group valid map memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module hpti_valid_ram
  import hpti_pkg::*;
#(
  parameter int unsigned ADDR_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire valid_map_t        wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output valid_map_t             rdata_o
);

  localparam int unsigned Depth = 1 << ADDR_W;

  valid_map_t mem_q [Depth];
  valid_map_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/hpti_entry_store.sv -----
// page table entry memory, 64-bit entries, written by the insert sequencer
`timescale 1ns / 1ps
`default_nettype none

module hpti_entry_store
  import hpti_pkg::*;
#(
  parameter int unsigned ADDR_W = 13
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [ADDR_W-1:0]  waddr_i,
  input  wire logic [ENTRY_W-1:0] wdata_i
);

  localparam int unsigned Depth = 1 << ADDR_W;

  logic [ENTRY_W-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hpti_slot_finder.sv -----
// shared first-free-slot search over one group's valid byte
`timescale 1ns / 1ps
`default_nettype none

module hpti_slot_finder
  import hpti_pkg::*;
(
  input  wire valid_map_t valid_map_i,
  output free_t           free_o
);

  // scan from the top so the lowest free slot wins
  always_comb begin
    free_o = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!valid_map_i[s]) begin
        free_o.found = 1'b1;
        free_o.slot  = SLOT_W'(s);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hpti_checker.sv -----
// port-level checks for the page table insert unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_page_table_insert_unit_macros.svh"

module hpti_checker
  import hpti_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_o
);

  // a failed insert carries no location and no entry
  `HPTI_ASSERT_ALWAYS(a_fail_clean, clk_i, rst_ni, !(out_valid_o && !out_o.inserted) || (!out_o.used_secondary && out_o.group_index == '0 && out_o.slot == '0 && out_o.entry_high == '0 && out_o.entry_low == '0))

  // a written entry is valid, its hash flag matches the group used, R, C and reserved bits clear
  `HPTI_ASSERT_ALWAYS(a_entry_form, clk_i, rst_ni, !(out_valid_o && out_o.inserted) || (out_o.entry_high[31] && out_o.entry_high[6] == out_o.used_secondary && out_o.entry_high[30:26] == '0 && out_o.entry_low[11:7] == '0 && out_o.entry_low[2] == 1'b0))

  // the unit is busy in the cycle after it takes a transaction
  `HPTI_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a stalled result stays
  `HPTI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_o))

endmodule

bind hashed_page_table_insert_unit hpti_checker u_hpti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

`default_nettype wire

// ----- tb/hpti_insert_checker.sv -----
// scoreboard for the page table insert unit: predicts every insert and checks each result
`timescale 1ns / 1ps

module hpti_insert_checker
  import hpti_pkg::*;
#(
  parameter int unsigned TABLE_LOG2 = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  localparam int unsigned GROUP_BITS = TABLE_LOG2 - 6;
  localparam int unsigned GROUPS     = 1 << GROUP_BITS;
  localparam int unsigned PRIMARY    = 0;
  localparam int unsigned SECONDARY  = 1;

  valid_map_t  group_valid [GROUPS];
  out_t        expected_q [$];
  out_t        want;
  int unsigned errors = 0;
  int unsigned outstanding = 0;

  assign error_count_o = errors;
  assign pending_o     = outstanding;

  // first free slot of the primary group, else of the secondary group; marks it taken
  function automatic out_t predict_insert(input in_t item);
    logic [31:0] hash;
    logic [31:0] grp;
    int unsigned side;
    int unsigned s;
    out_t        res;
    res  = '0;
    hash = {13'b0, item.segment_id} ^ {16'b0, item.effective_page[15:0]};
    for (side = PRIMARY; side <= SECONDARY && !res.inserted; side++) begin
      grp = ((side == SECONDARY) ? ~hash : hash) & (GROUPS - 1);
      for (s = 0; s < SLOTS && !res.inserted; s++) begin
        if (!group_valid[grp[GROUP_BITS-1:0]][s[SLOT_W-1:0]]) begin
          group_valid[grp[GROUP_BITS-1:0]][s[SLOT_W-1:0]] = 1'b1;
          res.inserted       = 1'b1;
          res.used_secondary = (side == SECONDARY);
          res.group_index    = grp[OUT_GRP_W-1:0];
          res.slot           = s[SLOT_W-1:0];
          res.entry_high     = {1'b1, 5'b0, item.segment_id, res.used_secondary,
                                item.effective_page[15:10]};
          // R and C always cleared, reserved bits zero
          res.entry_low      = {item.physical_page, 3'b0, 1'b0, 1'b0, item.attributes,
                                1'b0, item.protection};
        end
      end
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (group_valid[i]) group_valid[i] = '0;
      expected_q.delete();
      outstanding = 0;
    end else begin
      // results leave only after their insert has been taken, so retire first
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no insert outstanding: %p", out_i);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("inserted", 32'(want.inserted), 32'(out_i.inserted));
          check_field("used_secondary", 32'(want.used_secondary),
                      32'(out_i.used_secondary));
          check_field("group_index", 32'(want.group_index), 32'(out_i.group_index));
          check_field("slot", 32'(want.slot), 32'(out_i.slot));
          check_field("entry_high", want.entry_high, out_i.entry_high);
          check_field("entry_low", want.entry_low, out_i.entry_low);
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_insert(in_i));
      outstanding = expected_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// testbench top for the page table insert unit: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import hpti_pkg::*;

  localparam int unsigned TABLE_LOG2      = 16;
  localparam int unsigned GROUP_BITS      = TABLE_LOG2 - 6;
  localparam int unsigned GROUP_MASK      = (1 << GROUP_BITS) - 1;
  localparam int unsigned RANDOM_INSERTS  = 1900;
  localparam int unsigned HOT_GROUPS      = 12;
  localparam int unsigned HOT_W           = $clog2(HOT_GROUPS);
  localparam int unsigned HOT_REFRESH     = 300;
  localparam int unsigned HOLD_OFF_ROUND  = 30;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned FILL_GROUP      = 'h2A5;
  localparam int unsigned FILL_INSERTS    = 2 * SLOTS + 1;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_t         in_data   = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  out_t        out_data;
  int unsigned errors;
  int unsigned outstanding;
  logic [31:0] hot_group [HOT_GROUPS];

  always #5 clk = ~clk;

  hashed_page_table_insert_unit #(
    .TABLE_LOG2(TABLE_LOG2)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  hpti_insert_checker #(
    .TABLE_LOG2(TABLE_LOG2)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_i         (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_i        (out_data),
    .error_count_o(errors),
    .pending_o    (outstanding)
  );

  function automatic in_t make_insert(input logic [VSID_W-1:0] vsid,
                                      input logic [PAGE_W-1:0] page,
                                      input logic [RPN_W-1:0] rpn,
                                      input logic [WIMG_W-1:0] wimg,
                                      input logic [PP_W-1:0] pp);
    in_t item;
    item.segment_id     = vsid;
    item.effective_page = page;
    item.physical_page  = rpn;
    item.attributes     = wimg;
    item.protection     = pp;
    return item;
  endfunction

  function automatic in_t random_insert();
    return make_insert(VSID_W'($urandom), PAGE_W'($urandom), RPN_W'($urandom),
                       WIMG_W'($urandom), PP_W'($urandom));
  endfunction

  // random mapping whose primary hash lands on the given group
  function automatic in_t aimed_insert(input logic [31:0] grp);
    in_t item;
    item = random_insert();
    item.effective_page[GROUP_BITS-1:0] = item.segment_id[GROUP_BITS-1:0] ^ grp[GROUP_BITS-1:0];
    return item;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer_insert(input in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned r;
    logic        calm;
    in_t         item;
    calm = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, each attribute bit alone, every protection value
    offer_insert(make_insert(19'h00000, 20'h00000, 20'h00000, 4'h0, 2'h0));
    idle_sender(sender_gap());
    offer_insert(make_insert(19'h7FFFF, 20'hFFFFF, 20'hFFFFF, 4'hF, 2'h3));
    idle_sender(sender_gap());
    offer_insert(make_insert(19'h40000, 20'h80000, 20'h80000, 4'h8, 2'h1));
    idle_sender(sender_gap());
    offer_insert(make_insert(19'h2AAAA, 20'h55555, 20'hAAAAA, 4'h4, 2'h2));
    idle_sender(sender_gap());
    offer_insert(make_insert(19'h55555, 20'hAAAAA, 20'h55555, 4'h2, 2'h0));
    idle_sender(sender_gap());
    offer_insert(make_insert(19'h00001, 20'h0FC00, 20'h00001, 4'h1, 2'h3));
    idle_sender(sender_gap());

    // fill primary then secondary group of one hash, the last insert finds both full
    for (n = 0; n < FILL_INSERTS; n++) offer_insert(aimed_insert(FILL_GROUP));

    for (n = 0; n < RANDOM_INSERTS; n++) begin
      if (n % HOT_REFRESH == 0) begin
        foreach (hot_group[i]) hot_group[i] = $urandom_range(0, GROUP_MASK);
      end
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      // mostly aim at a few hot group pairs so they fill up and overflow
      r = $urandom_range(0, 99);
      if (r < 65) begin
        item = aimed_insert(hot_group[HOT_W'($urandom_range(0, HOT_GROUPS - 1))]);
        if ($urandom_range(0, 1)) item.effective_page[GROUP_BITS-1:0] =
            ~item.effective_page[GROUP_BITS-1:0];
      end else begin
        item = random_insert();
      end
      offer_insert(item);
      idle_sender(calm ? 0 : sender_gap());
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("hashed_page_table_insert_unit test passed");
    end else begin
      $display("hashed_page_table_insert_unit test failed");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off so the unit backs up into its input
  initial begin
    int unsigned round;
    int unsigned hold;
    int unsigned run;
    int unsigned r;
    round = 0;
    wait (rst_n);
    do @(posedge clk); while (in_stall);
    forever begin
      round++;
      r = $urandom_range(0, 99);
      if (round == HOLD_OFF_ROUND) hold = HOLD_OFF_CYCLES;
      else if (r < 80) hold = $urandom_range(1, 2);
      else hold = $urandom_range(6, 30);
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 60) run = $urandom_range(1, 3);
      else if (r < 90) run = $urandom_range(4, 12);
      else run = $urandom_range(30, 80);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("hashed_page_table_insert_unit test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/hpti_pkg.sv
hw/rtl/hpti_valid_ram.sv
hw/rtl/hpti_entry_store.sv
hw/rtl/hpti_slot_finder.sv
hw/rtl/hashed_page_table_insert_unit.sv
hw/rtl/hpti_checker.sv
tb/hpti_insert_checker.sv
tb/tb_top.sv
